// ===== src/ptms_pkg.sv =====
// shared types and constants for the process table scheduler
package ptms_pkg;

    localparam int SLOTS   = 64;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int STATE_W = 2;
    localparam int ID_W    = 16;
    localparam int PRIO_W  = 8;
    localparam int TICK_W  = 7;
    localparam int FUNC_W  = 3;
    localparam int MODE_W  = 2;
    localparam int ACT_W   = 2;
    localparam int OSLOT_W = 6;

    localparam int TICK_DEMOTE = 4;
    localparam int TICK_DECAY  = 8;
    localparam int TICK_BOOST  = 100;

    // operations
    localparam logic [FUNC_W-1:0] FN_ALLOC     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_SET_STATE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SET_PRIO  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TICK      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_PICK      = 3'd4;

    // slot states
    localparam logic [STATE_W-1:0] ST_UNUSED   = 2'd0;
    localparam logic [STATE_W-1:0] ST_BLOCKED  = 2'd1;
    localparam logic [STATE_W-1:0] ST_RUNNABLE = 2'd2;
    localparam logic [STATE_W-1:0] ST_RUNNING  = 2'd3;

    // scheduling modes
    localparam logic [MODE_W-1:0] MODE_RR    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOWID = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MLFQ  = 2'd2;

    // tick results
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_EXPIRE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_BOOST  = 2'd2;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [ID_W-1:0]    id;
        logic               level;
        logic [PRIO_W-1:0]  prio;
        logic [TICK_W-1:0]  ticks;
    } slot_ent_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        slot_ent_t        wr_ent;
        logic             boost;
    } tbl_req_t;

    typedef struct packed {
        logic               found;
        logic [OSLOT_W-1:0] slot;
        logic [ID_W-1:0]    id;
        logic               level;
        logic [ACT_W-1:0]   action;
    } result_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_READ,
        CS_SCAN,
        CS_DRAIN,
        CS_FINISH
    } ctrl_state_t;

endpackage

// ===== src/ptms_ram.sv =====
// generic single-port-write, registered-read ram
module ptms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/ptms_table.sv =====
// slot table: ram plus per-entry valid bits for reset and boost
module ptms_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  ptms_pkg::tbl_req_t  req,
    output ptms_pkg::slot_ent_t rd_ent
);
    import ptms_pkg::*;

    // valid_a covers state and id, valid_b covers level, priority and ticks
    logic [SLOTS-1:0] valid_a_reg, valid_a_next;
    logic [SLOTS-1:0] valid_b_reg, valid_b_next;
    logic [IDX_W-1:0] rd_addr_reg;
    slot_ent_t        ram_ent;
    logic [$bits(slot_ent_t)-1:0] ram_rd_data;

    ptms_ram #(
        .WIDTH ($bits(slot_ent_t)),
        .DEPTH (SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_ent),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_rd_data)
    );

    assign ram_ent = ram_rd_data;

    always_comb begin
        valid_a_next = valid_a_reg;
        valid_b_next = valid_b_reg;
        if (req.boost) begin
            valid_b_next = '0;
        end
        if (req.wr_en) begin
            valid_a_next[req.wr_addr] = 1'b1;
            valid_b_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= '0;
            valid_b_reg <= '0;
        end else begin
            valid_a_reg <= valid_a_next;
            valid_b_reg <= valid_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_addr_reg <= req.rd_addr;
        end
    end

    // entries never written since reset read as zero; since a boost, their level, priority and ticks do
    always_comb begin
        rd_ent = ram_ent;
        if (!valid_a_reg[rd_addr_reg]) begin
            rd_ent.state = ST_UNUSED;
            rd_ent.id    = '0;
        end
        if (!valid_a_reg[rd_addr_reg] || !valid_b_reg[rd_addr_reg]) begin
            rd_ent.level = 1'b0;
            rd_ent.prio  = '0;
            rd_ent.ticks = '0;
        end
    end

endmodule

// ===== src/ptms_ctrl.sv =====
// operation sequencer: single-slot read-modify-write and table scans
module ptms_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [ptms_pkg::MODE_W-1:0]        sched_mode,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ptms_pkg::FUNC_W-1:0]        s_func,
    input  logic [ptms_pkg::OSLOT_W-1:0]       s_slot_index,
    input  logic [ptms_pkg::ID_W-1:0]          s_proc_id,
    input  logic [ptms_pkg::STATE_W-1:0]       s_new_state,
    input  logic [ptms_pkg::PRIO_W-1:0]        s_new_priority,
    output ptms_pkg::tbl_req_t                 req,
    input  ptms_pkg::slot_ent_t                rd_ent,
    input  logic                               out_free,
    output logic                               res_valid,
    output ptms_pkg::result_t                  res
);
    import ptms_pkg::*;

    ctrl_state_t         state_reg, state_next;
    logic [FUNC_W-1:0]   func_reg, func_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                ok_reg, ok_next;
    logic [ID_W-1:0]     pid_reg, pid_next;
    logic [STATE_W-1:0]  nstate_reg, nstate_next;
    logic [PRIO_W-1:0]   nprio_reg, nprio_next;
    slot_ent_t           ent_reg, ent_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                hit_reg, hit_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    slot_ent_t           best_ent_reg, best_ent_next;
    logic [IDX_W-1:0]    rr_ptr_reg, rr_ptr_next;

    logic             rr_mode;
    logic             in_table;
    logic [IDX_W-1:0] scan_start;
    logic [IDX_W:0]   scan_sum;
    logic [IDX_W-1:0] scan_addr;
    logic             take;

    assign rr_mode  = (sched_mode != MODE_LOWID) && (sched_mode != MODE_MLFQ);
    assign in_table = (32'(s_slot_index) < SLOTS);

    // round-robin picks start at the pointer and wrap
    assign scan_start = ((func_reg == FN_PICK) && rr_mode) ? rr_ptr_reg : '0;
    assign scan_sum   = {1'b0, scan_start} + {1'b0, cnt_reg};
    assign scan_addr  = (scan_sum >= (IDX_W+1)'(SLOTS)) ?
                        IDX_W'(scan_sum - (IDX_W+1)'(SLOTS)) : IDX_W'(scan_sum);

    // candidate selection for the entry coming out of the table
    always_comb begin
        take = 1'b0;
        if (func_reg == FN_SET_PRIO) begin
            take = (rd_ent.state != ST_UNUSED) && (rd_ent.id == pid_reg) && !hit_reg;
        end else if (rd_ent.state == ST_RUNNABLE) begin
            if (!hit_reg) begin
                take = 1'b1;
            end else if (sched_mode == MODE_LOWID) begin
                take = rd_ent.id < best_ent_reg.id;
            end else if (sched_mode == MODE_MLFQ) begin
                take = best_ent_reg.level &&
                       (!rd_ent.level || (rd_ent.prio > best_ent_reg.prio));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            rr_ptr_reg  <= '0;
            rd_pend_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rr_ptr_reg  <= rr_ptr_next;
            rd_pend_reg <= rd_pend_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        idx_reg      <= idx_next;
        ok_reg       <= ok_next;
        pid_reg      <= pid_next;
        nstate_reg   <= nstate_next;
        nprio_reg    <= nprio_next;
        ent_reg      <= ent_next;
        cnt_reg      <= cnt_next;
        rd_idx_reg   <= rd_idx_next;
        best_idx_reg <= best_idx_next;
        best_ent_reg <= best_ent_next;
    end

    always_comb begin
        slot_ent_t         wr;
        logic [TICK_W-1:0] tick_t;

        state_next    = state_reg;
        func_next     = func_reg;
        idx_next      = idx_reg;
        ok_next       = ok_reg;
        pid_next      = pid_reg;
        nstate_next   = nstate_reg;
        nprio_next    = nprio_reg;
        ent_next      = ent_reg;
        cnt_next      = cnt_reg;
        rd_pend_next  = rd_pend_reg;
        rd_idx_next   = rd_idx_reg;
        hit_next      = hit_reg;
        best_idx_next = best_idx_reg;
        best_ent_next = best_ent_reg;
        rr_ptr_next   = rr_ptr_reg;
        req           = '0;
        res           = '0;
        res_valid     = 1'b0;
        s_ready       = 1'b0;
        wr            = ent_reg;
        tick_t        = ent_reg.ticks + TICK_W'(1);

        if (rd_pend_reg && take) begin
            hit_next      = 1'b1;
            best_idx_next = rd_idx_reg;
            best_ent_next = rd_ent;
        end

        unique case (state_reg)
            CS_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    func_next    = s_func;
                    idx_next     = IDX_W'(s_slot_index);
                    ok_next      = in_table;
                    pid_next     = s_proc_id;
                    nstate_next  = s_new_state;
                    nprio_next   = s_new_priority;
                    cnt_next     = '0;
                    rd_pend_next = 1'b0;
                    hit_next     = 1'b0;
                    if ((s_func == FN_ALLOC) || (s_func == FN_SET_STATE) ||
                        (s_func == FN_TICK)) begin
                        if (in_table) begin
                            req.rd_en   = 1'b1;
                            req.rd_addr = IDX_W'(s_slot_index);
                            state_next  = CS_READ;
                        end else begin
                            state_next = CS_FINISH;
                        end
                    end else if ((s_func == FN_SET_PRIO) || (s_func == FN_PICK)) begin
                        state_next = CS_SCAN;
                    end else begin
                        state_next = CS_FINISH;
                    end
                end
            end
            CS_READ: begin
                ent_next   = rd_ent;
                state_next = CS_FINISH;
            end
            CS_SCAN: begin
                req.rd_en    = 1'b1;
                req.rd_addr  = scan_addr;
                rd_pend_next = 1'b1;
                rd_idx_next  = scan_addr;
                cnt_next     = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(SLOTS - 1)) begin
                    state_next = CS_DRAIN;
                end
            end
            CS_DRAIN: begin
                rd_pend_next = 1'b0;
                state_next   = CS_FINISH;
            end
            CS_FINISH: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = CS_IDLE;
                    unique case (func_reg)
                        FN_ALLOC: begin
                            if (ok_reg && (ent_reg.state == ST_UNUSED)) begin
                                req.wr_en   = 1'b1;
                                req.wr_addr = idx_reg;
                                req.wr_ent  = '{state: ST_RUNNABLE, id: pid_reg,
                                                level: 1'b0, prio: '0, ticks: '0};
                            end
                        end
                        FN_SET_STATE: begin
                            wr.state    = nstate_reg;
                            req.wr_en   = ok_reg;
                            req.wr_addr = idx_reg;
                            req.wr_ent  = wr;
                        end
                        FN_SET_PRIO: begin
                            if (hit_reg) begin
                                wr          = best_ent_reg;
                                wr.prio     = nprio_reg;
                                req.wr_en   = 1'b1;
                                req.wr_addr = best_idx_reg;
                                req.wr_ent  = wr;
                                res.found   = 1'b1;
                                res.slot    = OSLOT_W'(best_idx_reg);
                                res.id      = best_ent_reg.id;
                            end
                        end
                        FN_TICK: begin
                            if (ok_reg) begin
                                wr.ticks   = tick_t;
                                res.action = ACT_NONE;
                                if (sched_mode == MODE_MLFQ) begin
                                    if (!ent_reg.level) begin
                                        if ((tick_t % TICK_W'(TICK_DEMOTE)) == '0) begin
                                            wr.level   = 1'b1;
                                            wr.ticks   = '0;
                                            res.action = ACT_EXPIRE;
                                        end
                                    end else if ((tick_t == '0) ||
                                                 (tick_t == TICK_W'(TICK_BOOST))) begin
                                        // whole-table boost clears this slot as well
                                        wr.level   = 1'b0;
                                        req.boost  = 1'b1;
                                        res.action = ACT_BOOST;
                                    end else if ((tick_t % TICK_W'(TICK_DECAY)) == '0) begin
                                        if (ent_reg.prio != '0) begin
                                            wr.prio = ent_reg.prio - PRIO_W'(1);
                                        end
                                        res.action = ACT_EXPIRE;
                                    end
                                end
                                req.wr_en   = !req.boost;
                                req.wr_addr = idx_reg;
                                req.wr_ent  = wr;
                                res.level   = wr.level;
                            end
                        end
                        FN_PICK: begin
                            if (hit_reg) begin
                                wr          = best_ent_reg;
                                wr.state    = ST_RUNNING;
                                req.wr_en   = 1'b1;
                                req.wr_addr = best_idx_reg;
                                req.wr_ent  = wr;
                                if (rr_mode) begin
                                    rr_ptr_next = (best_idx_reg == IDX_W'(SLOTS - 1)) ?
                                                  '0 : best_idx_reg + IDX_W'(1);
                                end
                                res.found = 1'b1;
                                res.slot  = OSLOT_W'(best_idx_reg);
                                res.id    = best_ent_reg.id;
                                res.level = best_ent_reg.level;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
    end

endmodule

// ===== src/process_table_mlfq_scheduler_core.sv =====
// top level of the process table scheduler: config register, sequencer, table, result register
//
// The block holds a table of 64 process slots in a single ram with a registered
// read; every defined operation reads that ram and may write a slot back. Allocate,
// set state and tick touch one slot: an item is taken, its slot is read, and the
// result beat is loaded into the output register once it is free; no new item is
// taken until then. Set priority and pick walk the whole table through the single
// read port, one slot per cycle, so the scan length is what sets their rate. The
// whole table is empty right after reset (per-slot valid flops, no clearing pass),
// and a feedback boost clears level, priority and ticks of all slots at once the
// same way. A new item may be accepted while the previous result beat still
// waits in the output register. sched_mode is written through the cfg channel
// and should only change while no item is in flight.
module process_table_mlfq_scheduler_core (
    input  logic                               aclk,
    input  logic                               aresetn,

    // configuration: scheduling mode
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ptms_pkg::MODE_W-1:0]        cfg_sched_mode,

    // operation beats
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ptms_pkg::FUNC_W-1:0]        s_func,
    input  logic [ptms_pkg::OSLOT_W-1:0]       s_slot_index,
    input  logic [ptms_pkg::ID_W-1:0]          s_proc_id,
    input  logic [ptms_pkg::STATE_W-1:0]       s_new_state,
    input  logic [ptms_pkg::PRIO_W-1:0]        s_new_priority,

    // result beats
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_found,
    output logic [ptms_pkg::OSLOT_W-1:0]       m_chosen_slot,
    output logic [ptms_pkg::ID_W-1:0]          m_chosen_id,
    output logic                               m_chosen_level,
    output logic [ptms_pkg::ACT_W-1:0]         m_tick_action
);
    import ptms_pkg::*;

    logic [MODE_W-1:0] sched_mode_reg, sched_mode_next;
    logic              m_valid_reg, m_valid_next;
    result_t           res_reg;

    tbl_req_t  req;
    slot_ent_t rd_ent;
    logic      out_free;
    logic      res_valid;
    result_t   res;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_comb begin
        sched_mode_next = sched_mode_reg;
        if (cfg_valid) begin
            sched_mode_next = cfg_sched_mode;
        end
    end

    // output register may be refilled in the cycle its beat leaves
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sched_mode_reg <= MODE_RR;
            m_valid_reg    <= 1'b0;
        end else begin
            sched_mode_reg <= sched_mode_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // result payload, loaded only when the sequencer finishes an item
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

    ptms_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sched_mode     (sched_mode_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_slot_index   (s_slot_index),
        .s_proc_id      (s_proc_id),
        .s_new_state    (s_new_state),
        .s_new_priority (s_new_priority),
        .req            (req),
        .rd_ent         (rd_ent),
        .out_free       (out_free),
        .res_valid      (res_valid),
        .res            (res)
    );

    ptms_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rd_ent  (rd_ent)
    );

    assign m_valid        = m_valid_reg;
    assign m_found        = res_reg.found;
    assign m_chosen_slot  = res_reg.slot;
    assign m_chosen_id    = res_reg.id;
    assign m_chosen_level = res_reg.level;
    assign m_tick_action  = res_reg.action;

endmodule

// ===== dv/ptms_sched_tb_pkg.sv =====
`timescale 1ns / 1ps
// operation beat type and slot table scoreboard for the scheduler testbench
package ptms_sched_tb_pkg;
    import ptms_pkg::*;

    // spare mode encoding, schedules as round-robin
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [OSLOT_W-1:0] slot;
        logic [ID_W-1:0]    pid;
        logic [STATE_W-1:0] nstate;
        logic [PRIO_W-1:0]  nprio;
    } sched_op_t;

    class slot_table_scoreboard;
        logic [STATE_W-1:0] state_q [SLOTS];
        logic [ID_W-1:0]    id_q    [SLOTS];
        logic               level_q [SLOTS];
        logic [PRIO_W-1:0]  prio_q  [SLOTS];
        logic [TICK_W-1:0]  ticks_q [SLOTS];
        int unsigned        rr_next;
        logic [MODE_W-1:0]  mode;
        result_t            expected_results [$];
        int unsigned        errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                state_q[i] = ST_UNUSED;
                id_q[i]    = '0;
                level_q[i] = 1'b0;
                prio_q[i]  = '0;
                ticks_q[i] = '0;
            end
            rr_next = 0;
            mode    = MODE_RR;
            errors  = 0;
        endfunction

        function void set_mode(logic [MODE_W-1:0] m);
            mode = m;
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        // returns SLOTS when nothing is runnable
        function int unsigned choose_slot();
            int unsigned best;
            int unsigned s;
            best = SLOTS;
            if (mode == MODE_LOWID) begin
                for (int i = 0; i < SLOTS; i++)
                    if (state_q[i] == ST_RUNNABLE && (best == SLOTS || id_q[i] < id_q[best]))
                        best = i;
            end else if (mode == MODE_MLFQ) begin
                for (int i = 0; i < SLOTS; i++)
                    if (state_q[i] == ST_RUNNABLE && !level_q[i])
                        return i;
                for (int i = 0; i < SLOTS; i++)
                    if (state_q[i] == ST_RUNNABLE &&
                        (best == SLOTS || prio_q[i] > prio_q[best]))
                        best = i;
            end else begin
                for (int i = 0; i < SLOTS; i++) begin
                    s = (rr_next + i) % SLOTS;
                    if (state_q[s] == ST_RUNNABLE)
                        return s;
                end
            end
            return best;
        endfunction

        // apply one accepted operation and queue the result beat it must produce
        function void note_op(sched_op_t op);
            result_t           res;
            int unsigned       hit;
            logic [TICK_W-1:0] t;
            res = '0;
            case (op.func)
                FN_ALLOC: begin
                    if (state_q[op.slot] == ST_UNUSED) begin
                        state_q[op.slot] = ST_RUNNABLE;
                        id_q[op.slot]    = op.pid;
                        level_q[op.slot] = 1'b0;
                        prio_q[op.slot]  = '0;
                        ticks_q[op.slot] = '0;
                    end
                end
                FN_SET_STATE: state_q[op.slot] = op.nstate;
                FN_SET_PRIO: begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (state_q[i] != ST_UNUSED && id_q[i] == op.pid) begin
                            prio_q[i] = op.nprio;
                            res.found = 1'b1;
                            res.slot  = OSLOT_W'(i);
                            res.id    = id_q[i];
                            break;
                        end
                    end
                end
                FN_TICK: begin
                    t = ticks_q[op.slot] + 1'b1;
                    ticks_q[op.slot] = t;
                    if (mode == MODE_MLFQ) begin
                        if (!level_q[op.slot]) begin
                            if (t % TICK_DEMOTE == 0) begin
                                level_q[op.slot] = 1'b1;
                                ticks_q[op.slot] = '0;
                                res.action = ACT_EXPIRE;
                            end
                        end else if (t % TICK_BOOST == 0) begin
                            for (int i = 0; i < SLOTS; i++) begin
                                level_q[i] = 1'b0;
                                prio_q[i]  = '0;
                                ticks_q[i] = '0;
                            end
                            res.action = ACT_BOOST;
                        end else if (t % TICK_DECAY == 0) begin
                            if (prio_q[op.slot] != 0)
                                prio_q[op.slot] = prio_q[op.slot] - 1'b1;
                            res.action = ACT_EXPIRE;
                        end
                    end
                    res.level = level_q[op.slot];
                end
                FN_PICK: begin
                    hit = choose_slot();
                    if (hit < SLOTS) begin
                        state_q[hit] = ST_RUNNING;
                        if (mode != MODE_LOWID && mode != MODE_MLFQ)
                            rr_next = (hit + 1) % SLOTS;
                        res.found = 1'b1;
                        res.slot  = OSLOT_W'(hit);
                        res.id    = id_q[hit];
                        res.level = level_q[hit];
                    end
                end
                default: ;
            endcase
            expected_results.push_back(res);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("result beat with nothing expected: found=%0d slot=%0d id=%h",
                             got.found, got.slot, got.id);
                return;
            end
            want = expected_results.pop_front();
            if (got.found !== want.found || got.slot !== want.slot || got.id !== want.id ||
                got.level !== want.level || got.action !== want.action) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display({"result mismatch: expected found=%0d slot=%0d id=%h level=%0d ",
                              "action=%0d, got found=%0d slot=%0d id=%h level=%0d action=%0d"},
                             want.found, want.slot, want.id, want.level, want.action,
                             got.found, got.slot, got.id, got.level, got.action);
            end
        endfunction
    endclass

endpackage

// ===== dv/tb_process_table_mlfq_scheduler_core.sv =====
`timescale 1ns / 1ps
// top of the scheduler testbench: clock, reset, beat drivers and test sequence
module tb_process_table_mlfq_scheduler_core;
    import ptms_pkg::*;
    import ptms_sched_tb_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RX_HOLD_CYCLES = 400;
    // a full table scan plus margin, waited out before the verdict
    localparam int DRAIN_CYCLES   = 2 * SLOTS + 16;
    localparam int PHASE_OPS      = 220;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [MODE_W-1:0]    cfg_sched_mode = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [FUNC_W-1:0]    s_func         = '0;
    logic [OSLOT_W-1:0]   s_slot_index   = '0;
    logic [ID_W-1:0]      s_proc_id      = '0;
    logic [STATE_W-1:0]   s_new_state    = '0;
    logic [PRIO_W-1:0]    s_new_priority = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic                 m_found;
    logic [OSLOT_W-1:0]   m_chosen_slot;
    logic [ID_W-1:0]      m_chosen_id;
    logic                 m_chosen_level;
    logic [ACT_W-1:0]     m_tick_action;

    slot_table_scoreboard sb;
    // steady stretches: no gaps between beats on that side
    bit                   tx_steady = 1'b0;
    bit                   rx_steady = 1'b0;
    int unsigned          rx_beats  = 0;

    process_table_mlfq_scheduler_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_sched_mode (cfg_sched_mode),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_slot_index   (s_slot_index),
        .s_proc_id      (s_proc_id),
        .s_new_state    (s_new_state),
        .s_new_priority (s_new_priority),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_chosen_slot  (m_chosen_slot),
        .m_chosen_id    (m_chosen_id),
        .m_chosen_level (m_chosen_level),
        .m_tick_action  (m_tick_action)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // offer one operation beat after a random gap, return once it is taken
    // valid stays high across back-to-back beats, it is only lowered for a gap
    task automatic send_op(input sched_op_t op);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 39) == 0)
            tx_steady = !tx_steady;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= op.func;
        s_slot_index   <= op.slot;
        s_proc_id      <= op.pid;
        s_new_state    <= op.nstate;
        s_new_priority <= op.nprio;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // taken at this edge, predict right away
        sb.note_op(op);
    endtask

    // stop offering and wait for every outstanding result beat
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // mode register write, only issued with the block drained
    task automatic write_mode(input logic [MODE_W-1:0] mode);
        cfg_valid      <= 1'b1;
        cfg_sched_mode <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.set_mode(mode);
    endtask

    // one random operation, slots and ids biased so that ops collide
    function automatic sched_op_t rand_op();
        sched_op_t       op;
        int unsigned     roll;
        logic [ID_W-1:0] id_pool [6] = '{16'h0000, 16'h0001, 16'h0002,
                                         16'h00ff, 16'h8000, 16'hffff};
        roll = $urandom_range(0, 99);
        if (roll < 18)
            op.func = FN_ALLOC;
        else if (roll < 36)
            op.func = FN_SET_STATE;
        else if (roll < 50)
            op.func = FN_SET_PRIO;
        else if (roll < 75)
            op.func = FN_TICK;
        else if (roll < 97)
            op.func = FN_PICK;
        else
            op.func = FUNC_W'(FN_PICK + 1 + $urandom_range(0, 2));
        // half the traffic lands on a few hot slots
        op.slot   = ($urandom_range(0, 1) != 0) ? OSLOT_W'($urandom_range(0, 7))
                                                : OSLOT_W'($urandom);
        op.pid    = ($urandom_range(0, 9) < 4) ? id_pool[$urandom_range(0, 5)]
                                               : ID_W'($urandom);
        op.nstate = ($urandom_range(0, 9) < 4) ? ST_RUNNABLE : STATE_W'($urandom);
        op.nprio  = PRIO_W'($urandom);
        return op;
    endfunction

    // result side: random ready gaps, two long holds that back the block up
    // so that s_ready drops while the sender keeps offering
    initial begin : result_sink
        int      gap;
        result_t got;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_beats == 300 || rx_beats == 1300)
                gap = RX_HOLD_CYCLES;
            else
                gap = rx_steady ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 49) == 0)
                rx_steady = !rx_steady;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            // outputs sampled as they stood at the accepting edge
            got.found  = m_found;
            got.slot   = m_chosen_slot;
            got.id     = m_chosen_id;
            got.level  = m_chosen_level;
            got.action = m_tick_action;
            sb.check_result(got);
            rx_beats++;
        end
    end

    initial begin : stimulus
        sched_op_t         op;
        int unsigned       sent;
        int unsigned       kind;
        int unsigned       n;
        int unsigned       hot;
        logic [MODE_W-1:0] phase_modes [8];
        phase_modes = '{MODE_MLFQ, MODE_LOWID, MODE_RR, MODE_MLFQ,
                        MODE_SPARE, MODE_LOWID, MODE_MLFQ, MODE_RR};
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, id matching, in-use allocate, round-robin wrap
        write_mode(MODE_RR);
        send_op(sched_op_t'{FN_PICK,      6'd0,  16'h0000, ST_UNUSED,   8'h00});
        // unused slots hold id 0 but must never match
        send_op(sched_op_t'{FN_SET_PRIO,  6'd0,  16'h0000, ST_UNUSED,   8'hff});
        send_op(sched_op_t'{FN_ALLOC,     6'd0,  16'hffff, ST_UNUSED,   8'h00});
        send_op(sched_op_t'{FN_ALLOC,     6'd63, 16'h0000, ST_UNUSED,   8'h00});
        // slot already in use, ignored
        send_op(sched_op_t'{FN_ALLOC,     6'd0,  16'h1234, ST_UNUSED,   8'h00});
        send_op(sched_op_t'{FN_SET_PRIO,  6'd0,  16'h0000, ST_UNUSED,   8'hff});
        send_op(sched_op_t'{FN_SET_PRIO,  6'd0,  16'hffff, ST_UNUSED,   8'h00});
        send_op(sched_op_t'{FN_PICK,      6'd0,  16'h0000, ST_UNUSED,   8'h00});
        send_op(sched_op_t'{FN_PICK,      6'd0,  16'h0000, ST_UNUSED,   8'h00});
        // everything running now, nothing to pick
        send_op(sched_op_t'{FN_PICK,      6'd0,  16'h0000, ST_UNUSED,   8'h00});
        send_op(sched_op_t'{FN_SET_STATE, 6'd0,  16'h0000, ST_BLOCKED,  8'h00});
        send_op(sched_op_t'{FN_SET_STATE, 6'd63, 16'h0000, ST_RUNNABLE, 8'h00});
        // pointer wrapped to slot 0, scan has to go all the way round
        send_op(sched_op_t'{FN_PICK,      6'd0,  16'h0000, ST_UNUSED,   8'h00});
        send_op(sched_op_t'{FN_SET_STATE, 6'd63, 16'h0000, ST_UNUSED,   8'h00});
        send_op(sched_op_t'{FN_ALLOC,     6'd63, 16'ha5a5, ST_UNUSED,   8'h00});
        send_op(sched_op_t'{FN_TICK,      6'd63, 16'h0000, ST_UNUSED,   8'h00});
        // undefined operation codes with every field at its top
        for (int f = FN_PICK + 1; f < (1 << FUNC_W); f++)
            send_op(sched_op_t'{FUNC_W'(f), '1, '1, '1, '1});
        send_op(sched_op_t'{FN_SET_STATE, 6'd0,  16'h0000, ST_RUNNING,  8'h00});
        drain_results();

        // directed feedback: demotion on tick, then a pick that falls to level 1
        write_mode(MODE_MLFQ);
        repeat (4) send_op(sched_op_t'{FN_TICK, 6'd63, 16'h0000, ST_UNUSED, 8'h00});
        send_op(sched_op_t'{FN_PICK, 6'd0, 16'h0000, ST_UNUSED, 8'h00});

        // random phases, each under its own mode, block drained before each write
        foreach (phase_modes[p]) begin
            drain_results();
            write_mode(phase_modes[p]);
            sent = 0;
            while (sent < PHASE_OPS) begin
                kind = $urandom_range(0, 99);
                if (kind < 10) begin
                    // bring a run of neighboring slots to life
                    n   = $urandom_range(1, 6);
                    hot = $urandom_range(0, SLOTS - 1);
                    repeat (n) begin
                        op      = rand_op();
                        op.func = FN_ALLOC;
                        op.slot = OSLOT_W'(hot);
                        hot++;
                        send_op(op);
                    end
                    sent += n;
                end else if (kind < 25) begin
                    // hammer one slot with ticks; a long run always reaches the boost
                    if (phase_modes[p] == MODE_MLFQ && $urandom_range(0, 5) == 0)
                        n = $urandom_range(104, 112);
                    else
                        n = $urandom_range(1, 12);
                    op      = rand_op();
                    op.func = FN_TICK;
                    repeat (n) send_op(op);
                    sent += n;
                end else begin
                    send_op(rand_op());
                    sent++;
                end
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            if (sb.pending() != 0)
                $display("%0d expected result beats never arrived", sb.pending());
            $display("Regression FAIL");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin : watchdog
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
